// ----- hw/rtl/cka_pkg.sv -----
// cka_pkg: shared types, register codes and constants for the chroma key alpha block
// no dependencies; used by chroma_key_alpha and chroma_key_alpha_tb

package cka_pkg;

	// coordinate width used by default
	localparam int COORD_BITS_DEF = 16;

	// alpha one in q.16
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	// iterative section: 25 root steps, one excess step, 16 drop quotient steps, one rounding step
	localparam int SQ_STEPS   = 25;
	localparam int ADIV_STEPS = 16;
	localparam int DDIV_STEPS = 16;
	localparam int NMID       = SQ_STEPS + 1 + DDIV_STEPS + 1;

	// register reset values
	localparam logic [23:0] KEY_COLOR_RST   = 24'h00FF00;
	localparam logic [7:0]  KEY_COEFF_RST   = 8'd128;
	localparam logic [23:0] CIRCLE_BIAS_RST = 24'd256;

	typedef enum logic [2:0] {
		REG_KEY_COLOR,
		REG_KEY_COEFF,
		REG_CIRCLE_MODE,
		REG_CIRCLE_CENTER,
		REG_CIRCLE_RADIUS,
		REG_CIRCLE_OFFSET,
		REG_CIRCLE_BIAS,
		REG_DEBUG_COLOR
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
	} pix_t;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} mat_t;

	// state carried through the iterative section
	typedef struct packed {
		logic [23:0] rgb;
		logic        row;
		logic        outside;
		logic        adiv;
		logic [16:0] aval;
		logic [36:0] arem;
		logic [15:0] aquo;
		logic [49:0] sv;
		logic [49:0] sres;
		logic        dsat;
		logic [24:0] drem;
		logic [15:0] dquo;
		logic [16:0] drop;
	} mid_t;

endpackage

// ----- hw/rtl/chroma_key_alpha.sv -----
// chroma_key_alpha: chroma key alpha matte with circle falloff, one pixel per clock while pix_stall is low
// depends on cka_pkg (types, register codes, constants)
//
//   channel   signals                          direction   transaction
//   pixel     pix_valid, pix_stall, pix_data   in          coordinates and rgb
//   matte     mat_valid, mat_stall, mat_data   out         alpha and rgb
//   config    psel, penable, pwrite, paddr,    in/out      64-bit register write/read
//             pwdata, prdata, pready
//
// one pixel per clock while pix_stall is low; the pipeline length is set by the
// 25-step pipelined square root followed by the 16-step pipelined drop divider
// the key division runs alongside the square root in the same stages
// all stages advance together; a one-entry skid behind the output register
// takes the last pixel when the matte side stalls, then pix_stall rises
// arst_n clears valid bits and loads the register reset values; no clearing pass

module chroma_key_alpha #(
	parameter int COORD_BITS = cka_pkg::COORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	// pixel channel
	input  logic          pix_valid,
	output logic          pix_stall,
	input  cka_pkg::pix_t pix_data,
	// matte channel
	output logic          mat_valid,
	input  logic          mat_stall,
	output cka_pkg::mat_t mat_data,
	// register port
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [5:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready
);

	localparam int NMID = cka_pkg::NMID;

	// ---------------------------------------------------------------- registers

	logic [23:0]        key_color_q;
	logic [7:0]         key_coeff_q;
	logic [1:0]         circle_mode_q;
	logic [47:0]        circle_center_q;
	logic [23:0]        circle_radius_q;
	logic signed [23:0] circle_offset_q;
	logic [23:0]        circle_bias_q;
	logic [23:0]        debug_color_q;

	cka_pkg::cfg_reg_t reg_idx;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = cka_pkg::cfg_reg_t'(paddr[5:3]);
	assign wr_en   = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_color_q     <= cka_pkg::KEY_COLOR_RST;
			key_coeff_q     <= cka_pkg::KEY_COEFF_RST;
			circle_mode_q   <= '0;
			circle_center_q <= '0;
			circle_radius_q <= '0;
			circle_offset_q <= '0;
			circle_bias_q   <= cka_pkg::CIRCLE_BIAS_RST;
			debug_color_q   <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				cka_pkg::REG_KEY_COLOR:     key_color_q     <= pwdata[23:0];
				cka_pkg::REG_KEY_COEFF:     key_coeff_q     <= pwdata[7:0];
				cka_pkg::REG_CIRCLE_MODE:   circle_mode_q   <= pwdata[1:0];
				cka_pkg::REG_CIRCLE_CENTER: circle_center_q <= pwdata[47:0];
				cka_pkg::REG_CIRCLE_RADIUS: circle_radius_q <= pwdata[23:0];
				cka_pkg::REG_CIRCLE_OFFSET: circle_offset_q <= pwdata[23:0];
				cka_pkg::REG_CIRCLE_BIAS:   circle_bias_q   <= pwdata[23:0];
				cka_pkg::REG_DEBUG_COLOR:   debug_color_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			cka_pkg::REG_KEY_COLOR:     prdata = 64'(key_color_q);
			cka_pkg::REG_KEY_COEFF:     prdata = 64'(key_coeff_q);
			cka_pkg::REG_CIRCLE_MODE:   prdata = 64'(circle_mode_q);
			cka_pkg::REG_CIRCLE_CENTER: prdata = 64'(circle_center_q);
			cka_pkg::REG_CIRCLE_RADIUS: prdata = 64'(circle_radius_q);
			cka_pkg::REG_CIRCLE_OFFSET: prdata = 64'(unsigned'(circle_offset_q));
			cka_pkg::REG_CIRCLE_BIAS:   prdata = 64'(circle_bias_q);
			cka_pkg::REG_DEBUG_COLOR:   prdata = 64'(debug_color_q);
			default:                    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- helpers

	// channel minus coeff times the other two, exact integer (x256 scale)
	function automatic logic signed [17:0] reduce_ch(input logic [7:0] c, input logic [7:0] o1,
			input logic [7:0] o2, input logic [7:0] k);
		logic [16:0] p;
		p = k * (9'(o1) + 9'(o2));
		return signed'({2'b00, c, 8'h00}) - signed'({1'b0, p});
	endfunction

	// one step of the iterative section; j picks which units work in this stage
	function automatic cka_pkg::mid_t mid_step(input cka_pkg::mid_t m, input int j,
			input logic [35:0] dnm, input logic [23:0] rad, input logic [23:0] bia);
		cka_pkg::mid_t r;
		logic [36:0]   at;
		logic          age;
		logic [49:0]   sbit;
		logic [49:0]   strial;
		logic [24:0]   droot;
		logic [24:0]   dt;
		logic [24:0]   dsh;
		logic          dge;
		r      = m;
		at     = {m.arem[35:0], 1'b0};
		age    = at >= {1'b0, dnm};
		sbit   = '0;
		strial = '0;
		droot  = m.sres[24:0];
		dt     = '0;
		dsh    = {m.drem[23:0], 1'b0};
		dge    = dsh >= {1'b0, bia};

		// key division, one quotient bit a step, then rounding
		if (j < cka_pkg::ADIV_STEPS) begin
			r.arem = age ? at - {1'b0, dnm} : at;
			r.aquo = {m.aquo[14:0], age};
		end else if (j == cka_pkg::ADIV_STEPS) begin
			if (m.adiv) begin
				r.aval = cka_pkg::ONE_Q16 - (17'(m.aquo) + 17'(age));
			end
		end

		// distance root, then excess over radius, then drop division
		if (j < cka_pkg::SQ_STEPS) begin
			sbit   = 50'(1) << (2 * (cka_pkg::SQ_STEPS - 1 - j));
			strial = m.sres + sbit;
			if (m.sv >= strial) begin
				r.sv   = m.sv - strial;
				r.sres = (m.sres >> 1) + sbit;
			end else begin
				r.sres = m.sres >> 1;
			end
		end else if (j == cka_pkg::SQ_STEPS) begin
			dt     = (droot > {1'b0, rad}) ? droot - {1'b0, rad} : '0;
			r.dsat = dt >= {1'b0, bia};
			r.drem = dt;
			r.dquo = '0;
		end else if (j < cka_pkg::SQ_STEPS + 1 + cka_pkg::DDIV_STEPS) begin
			r.drem = dge ? dsh - {1'b0, bia} : dsh;
			r.dquo = {m.dquo[14:0], dge};
		end else begin
			// excess at or above bias drops the whole alpha
			r.drop = m.dsat ? cka_pkg::ONE_Q16 : 17'(m.dquo) + 17'(dge);
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- key terms from config

	// reduced key, its squares, the norm and the squared radius follow the registers
	logic signed [17:0] tk_q [3];
	logic [34:0]        tksq_q [3];
	logic [35:0]        denom_q;
	logic               denz_q;
	logic [47:0]        r2_q;
	logic signed [35:0] tksq_w [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tksq_w[i] = tk_q[i] * tk_q[i];
		end
	end

	always_ff @(posedge clk) begin
		tk_q[0]   <= reduce_ch(key_color_q[23:16], key_color_q[15:8], key_color_q[7:0],
			key_coeff_q);
		tk_q[1]   <= reduce_ch(key_color_q[15:8], key_color_q[23:16], key_color_q[7:0],
			key_coeff_q);
		tk_q[2]   <= reduce_ch(key_color_q[7:0], key_color_q[23:16], key_color_q[15:8],
			key_coeff_q);
		for (int i = 0; i < 3; i++) begin
			tksq_q[i] <= tksq_w[i][34:0];
		end
		denom_q   <= 36'(tksq_q[0]) + 36'(tksq_q[1]) + 36'(tksq_q[2]);
		denz_q    <= (tksq_q[0] == '0) && (tksq_q[1] == '0) && (tksq_q[2] == '0);
		r2_q      <= circle_radius_q * circle_radius_q;
	end

	// ---------------------------------------------------------------- flow control

	// every stage moves while the skid is empty
	logic en;
	logic skid_v_q;
	logic out_v_q;

	assign en        = !skid_v_q;
	assign pix_stall = skid_v_q;

	// ---------------------------------------------------------------- stage 1: reduce pixel, offsets

	logic               vld_s1;
	logic [23:0]        rgb_s1;
	logic signed [17:0] tp_s1 [3];
	logic signed [24:0] dx_s1;
	logic signed [24:0] dy_s1;
	logic               row_s1;

	logic [23:0]        x8;
	logic [23:0]        y8;
	logic signed [25:0] row_lim;

	always_comb begin
		x8      = 24'({pix_data.pixel_x[COORD_BITS-1:0], 8'h00});
		y8      = 24'({pix_data.pixel_y[COORD_BITS-1:0], 8'h00});
		row_lim = signed'({2'b00, circle_center_q[23:0]}) + 26'(circle_offset_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s1   <= {pix_data.red, pix_data.green, pix_data.blue};
			tp_s1[0] <= reduce_ch(pix_data.red, pix_data.green, pix_data.blue, key_coeff_q);
			tp_s1[1] <= reduce_ch(pix_data.green, pix_data.red, pix_data.blue, key_coeff_q);
			tp_s1[2] <= reduce_ch(pix_data.blue, pix_data.red, pix_data.green, key_coeff_q);
			dx_s1    <= signed'({1'b0, x8}) - signed'({1'b0, circle_center_q[47:24]});
			dy_s1    <= signed'({1'b0, y8}) - signed'({1'b0, circle_center_q[23:0]});
			// rows at or above center plus offset
			row_s1   <= signed'({2'b00, y8}) <= row_lim;
		end
	end

	// ---------------------------------------------------------------- stage 2: products

	logic               vld_s2;
	logic [23:0]        rgb_s2;
	logic signed [35:0] pk_s2 [3];
	logic [47:0]        dxx_s2;
	logic [47:0]        dyy_s2;
	logic               row_s2;
	logic signed [49:0] dxw;
	logic signed [49:0] dyw;

	always_comb begin
		dxw = dx_s1 * dx_s1;
		dyw = dy_s1 * dy_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s2 <= rgb_s1;
			for (int i = 0; i < 3; i++) begin
				pk_s2[i] <= tp_s1[i] * tk_q[i];
			end
			dxx_s2 <= dxw[47:0];
			dyy_s2 <= dyw[47:0];
			row_s2 <= row_s1;
		end
	end

	// ---------------------------------------------------------------- stage 3: sums

	logic               vld_s3;
	logic [23:0]        rgb_s3;
	logic signed [37:0] dot_s3;
	logic [48:0]        d2_s3;
	logic               row_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rgb_s3 <= rgb_s2;
			dot_s3 <= 38'(pk_s2[0]) + 38'(pk_s2[1]) + 38'(pk_s2[2]);
			d2_s3  <= 49'(dxx_s2) + 49'(dyy_s2);
			row_s3 <= row_s2;
		end
	end

	// ---------------------------------------------------------------- stage 4 and the iterative section

	// mid_s[0] holds the classified pixel, mid_s[j+1] the result of step j
	cka_pkg::mid_t mid_s [0:NMID];
	logic [NMID:0] mid_vld_s;
	cka_pkg::mid_t mid0;
	logic          dpos;

	always_comb begin
		dpos         = !dot_s3[37] && (dot_s3 != '0);
		mid0         = '0;
		mid0.rgb     = rgb_s3;
		mid0.row     = row_s3;
		mid0.outside = 49'(r2_q) < d2_s3;
		// zero norm or non-positive dot leaves the pixel opaque
		mid0.adiv    = !denz_q && dpos && (dot_s3[36:0] < {1'b0, denom_q});
		mid0.aval    = (denz_q || !dpos) ? cka_pkg::ONE_Q16 : '0;
		mid0.arem    = dot_s3[36:0];
		mid0.sv      = 50'(d2_s3);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s[0] <= mid0;
		end
	end

	for (genvar j = 0; j < NMID; j++) begin : g_mid
		always_ff @(posedge clk) begin
			if (en) begin
				mid_s[j+1] <= mid_step(mid_s[j], j, denom_q, circle_radius_q, circle_bias_q);
			end
		end
	end

	// ---------------------------------------------------------------- final stage: circle decision

	logic          fin_vld_s;
	logic [16:0]   fa_s;
	logic [23:0]   frgb_s;
	cka_pkg::mid_t mlast;
	logic          apply;
	logic [16:0]   fa_w;
	logic [23:0]   frgb_w;

	always_comb begin
		mlast  = mid_s[NMID];
		apply  = (circle_mode_q != '0) && mlast.row && mlast.outside &&
			(circle_mode_q[1] || ((mlast.aval != '0) && (mlast.aval != cka_pkg::ONE_Q16)));
		fa_w   = mlast.aval;
		frgb_w = mlast.rgb;
		if (apply) begin
			if (circle_mode_q[1]) begin
				// debug marking outside the radius
				fa_w   = cka_pkg::ONE_Q16;
				frgb_w = debug_color_q;
			end else if (circle_bias_q == '0) begin
				fa_w = '0;
			end else if (mlast.drop >= mlast.aval) begin
				fa_w = '0;
			end else begin
				fa_w = mlast.aval - mlast.drop;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fa_s   <= fa_w;
			frgb_s <= frgb_w;
		end
	end

	// valid bits of all stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			mid_vld_s <= '0;
			fin_vld_s <= 1'b0;
		end else if (en) begin
			vld_s1    <= pix_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			mid_vld_s <= {mid_vld_s[NMID-1:0], vld_s3};
			fin_vld_s <= mid_vld_s[NMID];
		end
	end

	// ---------------------------------------------------------------- output register and skid

	cka_pkg::mat_t fin_res;
	cka_pkg::mat_t out_q;
	cka_pkg::mat_t skid_q;
	logic [24:0]   ascale;

	always_comb begin
		// alpha * 255 rounded back to 8 bits
		ascale            = {fa_s, 8'h00} - 25'(fa_s) + 25'(32768);
		fin_res.alpha     = ascale[23:16];
		fin_res.out_red   = frgb_s[23:16];
		fin_res.out_green = frgb_s[15:8];
		fin_res.out_blue  = frgb_s[7:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (!mat_stall) begin
				skid_v_q <= 1'b0;
			end
		end else if (!out_v_q || !mat_stall) begin
			out_v_q <= fin_vld_s;
		end else if (fin_vld_s) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (!mat_stall) begin
				out_q <= skid_q;
			end
		end else if (!out_v_q || !mat_stall) begin
			out_q <= fin_res;
		end else begin
			skid_q <= fin_res;
		end
	end

	assign mat_valid = out_v_q;
	assign mat_data  = out_q;

	// ---------------------------------------------------------------- checks

`ifndef SYNTHESIS
	// a held skid entry always sits behind a shown transaction
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a transaction while output is empty");

	// a pixel leaving the last stage lands in the output or the skid
	a_last_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(en && fin_vld_s) |=> out_v_q)
		else $error("pixel from last stage lost");

	// integer root of a distance below 2^49 fits 25 bits
	a_root_width: assert property (@(posedge clk) disable iff (!arst_n)
		mid_vld_s[cka_pkg::SQ_STEPS] |-> (mid_s[cka_pkg::SQ_STEPS].sres[49:25] == '0))
		else $error("distance root out of range");
`endif

endmodule

// ----- bench/chroma_key_alpha_tb.sv -----
// chroma_key_alpha_tb: self-checking bench for the chroma key alpha matte block
// depends on cka_pkg (pixel and matte structs, register codes) and chroma_key_alpha

module chroma_key_alpha_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cka_pkg::*;

	// expected-matte store with its own copy of the register file
	class matte_board;
		logic [23:0] key_rgb = KEY_COLOR_RST;
		logic [7:0]  coeff   = KEY_COEFF_RST;
		logic [1:0]  mode    = '0;
		logic [47:0] center  = '0;
		logic [23:0] radius  = '0;
		logic [23:0] offset  = '0;
		logic [23:0] bias    = CIRCLE_BIAS_RST;
		logic [23:0] dbg_rgb = '0;
		mat_t        pending[$];
		int          errors  = 0;
		int          checked = 0;

		function void set_reg(cfg_reg_t r, logic [63:0] v);
			case (r)
				REG_KEY_COLOR:     key_rgb = v[23:0];
				REG_KEY_COEFF:     coeff   = v[7:0];
				REG_CIRCLE_MODE:   mode    = v[1:0];
				REG_CIRCLE_CENTER: center  = v[47:0];
				REG_CIRCLE_RADIUS: radius  = v[23:0];
				REG_CIRCLE_OFFSET: offset  = v[23:0];
				REG_CIRCLE_BIAS:   bias    = v[23:0];
				REG_DEBUG_COLOR:   dbg_rgb = v[23:0];
				default: ;
			endcase
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res;
			longint unsigned t;
			res = 0;
			for (int i = 25; i >= 0; i--) begin
				t = res | (64'd1 << i);
				if (t * t <= v)
					res = t;
			end
			return res;
		endfunction

		function mat_t matte_of(pix_t p);
			longint tp[3];
			longint tk[3];
			longint k, dot, den, a, cx, cy, off, dx, dy;
			longint unsigned d2, r2, droot, ex, drop;
			logic [7:0] r, g, b;
			bit dbg;
			mat_t m;
			k = coeff;
			r = p.red; g = p.green; b = p.blue;
			dbg = mode[1];
			tp[0] = 256 * longint'(r) - k * (longint'(g) + longint'(b));
			tp[1] = 256 * longint'(g) - k * (longint'(r) + longint'(b));
			tp[2] = 256 * longint'(b) - k * (longint'(r) + longint'(g));
			tk[0] = 256 * longint'(key_rgb[23:16])
				- k * (longint'(key_rgb[15:8]) + longint'(key_rgb[7:0]));
			tk[1] = 256 * longint'(key_rgb[15:8])
				- k * (longint'(key_rgb[23:16]) + longint'(key_rgb[7:0]));
			tk[2] = 256 * longint'(key_rgb[7:0])
				- k * (longint'(key_rgb[23:16]) + longint'(key_rgb[15:8]));
			dot = tp[0] * tk[0] + tp[1] * tk[1] + tp[2] * tk[2];
			den = tk[0] * tk[0] + tk[1] * tk[1] + tk[2] * tk[2];
			if (den == 0 || dot <= 0)
				a = 65536;
			else if (dot >= den)
				a = 0;
			else
				a = 65536 - (dot * 65536 + den / 2) / den;
			// circle only touches partial alphas unless debug marking is on
			if (mode != 0 && (dbg || (a != 0 && a != 65536))) begin
				cx = center[47:24];
				cy = center[23:0];
				off = longint'($signed(offset));
				if (longint'(p.pixel_y) * 256 <= cy + off) begin
					dx = longint'(p.pixel_x) * 256 - cx;
					dy = longint'(p.pixel_y) * 256 - cy;
					d2 = dx * dx + dy * dy;
					r2 = longint'(radius) * longint'(radius);
					if (d2 > r2) begin
						if (dbg) begin
							a = 65536;
							{r, g, b} = dbg_rgb;
						end else if (bias == 0) begin
							a = 0;
						end else begin
							droot = int_sqrt(d2);
							ex = (droot > radius) ? droot - radius : 0;
							drop = (ex * 65536 + bias / 2) / bias;
							a = (drop >= a) ? 0 : a - longint'(drop);
						end
					end
				end
			end
			m.alpha     = 8'((a * 255 + 32768) >> 16);
			m.out_red   = r;
			m.out_green = g;
			m.out_blue  = b;
			return m;
		endfunction

		function void note_pixel(pix_t p);
			pending.push_back(matte_of(p));
		endfunction

		function void check_matte(mat_t got);
			mat_t want;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected matte transaction %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("matte mismatch: alpha %0d/%0d rgb %h/%h (expected/actual)",
						want.alpha, got.alpha,
						{want.out_red, want.out_green, want.out_blue},
						{got.out_red, got.out_green, got.out_blue});
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pix_valid = 1'b0;
	logic        pix_stall;
	pix_t        pix_data = '0;
	logic        mat_valid;
	logic        mat_stall = 1'b0;
	mat_t        mat_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [5:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;

	matte_board board = new();

	// idle percentages for each side, and a long receiver hold-off on request
	int send_idle = 0;
	int recv_idle = 0;
	int hold_req  = 0;
	int hold_cnt  = 0;
	int sent      = 0;

	chroma_key_alpha dut (
		.clk, .arst_n,
		.pix_valid, .pix_stall, .pix_data,
		.mat_valid, .mat_stall, .mat_data,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always #5 clk = ~clk;

	// receiver: random stalls, or a counted hold-off so the pipe backs up
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			mat_stall <= 1'b1;
		end else begin
			mat_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	// every accepted matte transaction goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && mat_valid && !mat_stall)
			board.check_matte(mat_data);
	end

	// watchdog
	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

	// register write: setup phase then access phase, pready is tied high
	task automatic reg_write(cfg_reg_t r, logic [63:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 6'(r) << 3;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_reg(r, v);
	endtask

	// offer one pixel, optionally after random idle cycles, and hold it until taken
	task automatic send_pixel(pix_t p);
		while ($urandom_range(0, 99) < send_idle) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_data <= p;
		do
			@(posedge clk);
		while (pix_stall);
		board.note_pixel(p);
		sent++;
	endtask

	// stop offering, let every outstanding matte drain, then the pipe latency
	task automatic drain();
		pix_valid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic px(int x, int y, logic [23:0] rgb);
		pix_t p;
		p.pixel_x = 16'(x);
		p.pixel_y = 16'(y);
		{p.red, p.green, p.blue} = rgb;
		send_pixel(p);
	endtask

	task automatic write_all(logic [23:0] key, logic [7:0] k, logic [1:0] m, logic [47:0] c,
		logic [23:0] rad, logic [23:0] off, logic [23:0] bs, logic [23:0] dc);
		reg_write(REG_KEY_COLOR, 64'(key));
		reg_write(REG_KEY_COEFF, 64'(k));
		reg_write(REG_CIRCLE_MODE, 64'(m));
		reg_write(REG_CIRCLE_CENTER, 64'(c));
		reg_write(REG_CIRCLE_RADIUS, 64'(rad));
		reg_write(REG_CIRCLE_OFFSET, 64'(off));
		reg_write(REG_CIRCLE_BIAS, 64'(bs));
		reg_write(REG_DEBUG_COLOR, 64'(dc));
	endtask

	// random setting; the phase index forces some extremes
	task automatic random_setting(int ph);
		logic [23:0] key, rad, off, bs;
		logic [7:0]  k;
		logic [1:0]  m;
		logic [47:0] c;
		key = 24'($urandom());
		k   = 8'($urandom());
		m   = 2'($urandom_range(1, 3));
		c   = {24'($urandom_range(0, 300) << 8 | $urandom_range(0, 255)),
			24'($urandom_range(0, 300) << 8 | $urandom_range(0, 255))};
		rad = 24'($urandom_range(0, 120 << 8));
		off = 24'($signed($urandom_range(0, 200 << 8)) - (100 << 8));
		bs  = 24'($urandom_range(1, 64 << 8));
		case (ph)
			0: begin k = 8'd0; off = 24'h7FFFFF; end
			1: begin k = 8'd255; off = 24'h800000; bs = 24'hFFFFFF; end
			2: begin c = '1; rad = 24'hFFFFFF; m = 2'd2; end
			3: begin bs = 24'd0; m = 2'd1; end
			4: begin rad = 24'd0; c = '0; m = 2'd1; end
			default: ;
		endcase
		write_all(key, k, m, c, rad, off, bs, 24'($urandom()));
	endtask

	// mostly pixels around the circle, some near the key, some anywhere
	task automatic random_pixels(int n);
		pix_t p;
		logic [23:0] key;
		for (int i = 0; i < n; i++) begin
			key = board.key_rgb;
			if ($urandom_range(0, 3) == 0) begin
				p.pixel_x = 16'($urandom());
				p.pixel_y = 16'($urandom());
			end else begin
				p.pixel_x = 16'($urandom_range(0, 400));
				p.pixel_y = 16'($urandom_range(0, 400));
			end
			{p.red, p.green, p.blue} = 24'($urandom());
			if ($urandom_range(0, 2) == 0) begin
				p.red   = key[23:16] ^ 8'($urandom_range(0, 15));
				p.green = key[15:8] ^ 8'($urandom_range(0, 15));
				p.blue  = key[7:0] ^ 8'($urandom_range(0, 15));
			end
			send_pixel(p);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: green key, extremes of coordinates and colors
		px(0, 0, 24'h000000);
		px(65535, 65535, 24'hFFFFFF);
		px(1234, 4321, 24'h00FF00);
		px(7, 9, 24'hFF00FF);
		px(300, 2, 24'h20C040);
		drain();

		// gray key at half coefficient reduces to zero: key norm is zero
		write_all(24'h808080, 8'd128, 2'd0, '0, '0, '0, 24'd256, 24'h123456);
		px(5, 5, 24'h00FF00);
		px(5, 5, 24'hFF0000);
		drain();
		reg_write(REG_CIRCLE_MODE, 64'd2);   // debug marks even full alphas
		px(200, 0, 24'h00FF00);
		px(0, 0, 24'h00FF00);
		drain();

		// falloff with zero bias, a row below the affected band, a pixel inside
		write_all(24'h00FF00, 8'd64, 2'd1, {24'(100 << 8), 24'(100 << 8)}, 24'(20 << 8),
			'0, 24'd0, 24'hABCDEF);
		px(10, 10, 24'h40A040);
		px(100, 200, 24'h40A040);
		px(100, 95, 24'h40A040);
		px(100, 100, 24'h40A040);
		drain();

		// real falloff, negative offset, then debug marking via mode three
		write_all(24'h00FF00, 8'd64, 2'd1, {24'(100 << 8), 24'(100 << 8)}, 24'(20 << 8),
			24'(-(10 << 8)), 24'(4 << 8), 24'hABCDEF);
		px(70, 60, 24'h40A040);
		px(100, 75, 24'h50B050);
		px(100, 95, 24'h40A040);
		drain();
		reg_write(REG_CIRCLE_MODE, 64'd3);
		px(10, 10, 24'h40A040);
		px(100, 85, 24'hFFFFFF);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph / 2)
				0: begin send_idle = 32; recv_idle = 67; end
				1: begin send_idle = 67; recv_idle = 32; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			random_setting(ph);
			if (ph == 4) begin
				random_pixels(20);
				hold_req = 200;   // sender keeps going, pipe fills, pix_stall must rise
			end
			random_pixels(ph == 4 ? 70 : 90);
			drain();
		end

		$display("covered %0d pixels, %0d mattes checked, circle off/falloff/debug",
			sent, board.checked);
		$display("with all registers written at extreme and random settings");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/cka_pkg.sv
hw/rtl/chroma_key_alpha.sv
bench/chroma_key_alpha_tb.sv
